// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: screen geometry, field widths, command
// and character codes, and the constant-modulus reduction helper.
// No dependencies.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int IN_W   = 32;
    localparam int USER_W = 3;
    localparam int OUT_W  = 40;

    typedef logic [USER_W-1:0] cmd_t;

    localparam cmd_t CMD_LOCATE = 3'd0;
    localparam cmd_t CMD_PUT    = 3'd1;
    localparam cmd_t CMD_WRITE  = 3'd2;
    localparam cmd_t CMD_CLEAR  = 3'd3;
    localparam cmd_t CMD_READ   = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_NUL   = 8'd0;

    // Restoring reduction of a byte by a small constant modulus, eight steps.
    function automatic logic [7:0] mod_const(input logic [7:0] v, input int unsigned m);
        logic [15:0] acc;
        acc = {8'd0, v};
        for (int k = 7; k >= 0; k--) begin
            if (acc >= 16'(m << k)) begin
                acc = acc - 16'(m << k);
            end
        end
        return acc[7:0];
    endfunction

endpackage

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer: cursor control and a character/attribute cell memory.
// Depends on tcw_pkg.
// A request passes through the EXEC and DONE states and its result is then
// registered once the output is free; a new request is taken only in IDLE or in
// DONE with the output free. A put that scrolls and a clear walk the cell memory
// one cell per cycle through its single read and single write port.
// Reset (aresetn low, synchronous) homes the cursor, sets the default attribute
// to 7 and empties the output register; cell contents are undefined until written.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // char_code, attribute, col, row
    input  logic [USER_W-1:0] s_tuser,   // cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // read_char, read_attribute, cursor_col,
                                         // cursor_row, cursor_index, zero pad
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [7:0]        ch_reg, ch_next;
    logic [7:0]        attr_reg, attr_next;
    logic [COL_W-1:0]  col_in_reg, col_in_next;
    logic [ROW_W-1:0]  row_in_reg, row_in_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              scroll_reg, scroll_next;
    logic              wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_mem_reg, wr_mem_next;
    logic [CELL_W-1:0] wr_data_reg, wr_data_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [7:0]        dflt_attr_reg, dflt_attr_next;
    logic [CELL_W-1:0] rd_data_reg;

    logic [CELL_W-1:0] mem [CELLS];

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_free, in_acc, last_row, col_last, advance;
    logic [ADDR_W-1:0] cur_addr, in_addr;
    logic [ADDR_W:0]   ahead;
    logic [CELL_W-1:0] blank;
    logic [7:0]        rd_ch, rd_attr;
    logic [IDX_W-1:0]  cur_idx;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign last_row = (cur_row_reg == ROW_W'(ROWS - 1));
    assign col_last = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign cur_addr = ADDR_W'(int'(cur_row_reg) * COLUMNS + int'(cur_col_reg));
    assign in_addr  = ADDR_W'(int'(row_in_reg) * COLUMNS + int'(col_in_reg));
    assign cur_idx  = IDX_W'(int'(cur_row_reg) * COLUMNS + int'(cur_col_reg));
    assign ahead    = {1'b0, cnt_reg} + (ADDR_W + 1)'(COLUMNS);
    assign blank    = {dflt_attr_reg, CH_SPACE};
    assign advance  = (ch_reg == CH_LF) || ((ch_reg != CH_CR) && col_last);
    assign rd_ch    = (cmd_reg == CMD_READ) ? rd_data_reg[7:0] : 8'd0;
    assign rd_attr  = (cmd_reg == CMD_READ) ? rd_data_reg[15:8] : 8'd0;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ch_next        = ch_reg;
        attr_next      = attr_reg;
        col_in_next    = col_in_reg;
        row_in_next    = row_in_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cnt_next       = cnt_reg;
        scroll_next    = scroll_reg;
        wr_en_next     = 1'b0;
        wr_addr_next   = wr_addr_reg;
        wr_mem_next    = 1'b0;
        wr_data_next   = wr_data_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        dflt_attr_next = cfg_valid ? cfg_data : dflt_attr_reg;
        rd_en          = 1'b0;
        rd_addr        = cur_addr;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (in_acc) begin
            cmd_next    = s_tuser;
            ch_next     = s_tdata[7:0];
            attr_next   = s_tdata[15:8];
            col_in_next = COL_W'(mod_const(s_tdata[23:16], COLUMNS));
            row_in_next = ROW_W'(mod_const(s_tdata[31:24], ROWS));
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_LOCATE: begin
                        cur_col_next = col_in_reg;
                        cur_row_next = row_in_reg;
                    end
                    CMD_PUT: begin
                        if (ch_reg != CH_NUL) begin
                            if ((ch_reg != CH_CR) && (ch_reg != CH_LF)) begin
                                wr_en_next   = 1'b1;
                                wr_addr_next = cur_addr;
                                wr_data_next = {attr_reg, ch_reg};
                                cur_col_next = col_last ? '0 : cur_col_reg + COL_W'(1);
                            end
                            if (ch_reg == CH_CR) begin
                                cur_col_next = '0;
                            end
                            if (advance) begin
                                if (last_row) begin
                                    scroll_next = 1'b1;
                                    cnt_next    = '0;
                                    state_next  = ST_SWEEP;
                                end else begin
                                    cur_row_next = cur_row_reg + ROW_W'(1);
                                end
                            end
                        end
                    end
                    CMD_WRITE: begin
                        wr_en_next   = 1'b1;
                        wr_addr_next = in_addr;
                        wr_data_next = {attr_reg, ch_reg};
                    end
                    CMD_CLEAR: begin
                        scroll_next = 1'b0;
                        cnt_next    = '0;
                        state_next  = ST_SWEEP;
                    end
                    CMD_READ: begin
                        rd_en   = 1'b1;
                        rd_addr = in_addr;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SWEEP: begin
                wr_en_next   = 1'b1;
                wr_addr_next = cnt_reg;
                if (scroll_reg && (ahead < (ADDR_W + 1)'(CELLS))) begin
                    rd_en       = 1'b1;
                    rd_addr     = ahead[ADDR_W-1:0];
                    wr_mem_next = 1'b1;
                end else begin
                    wr_data_next = blank;
                end
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, cur_idx, cur_row_reg, cur_col_reg, rd_attr, rd_ch};
                    state_next    = in_acc ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            wr_en_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            dflt_attr_reg <= 8'd7;
        end else begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            wr_en_reg     <= wr_en_next;
            m_tvalid_reg  <= m_tvalid_next;
            dflt_attr_reg <= dflt_attr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        ch_reg      <= ch_next;
        attr_reg    <= attr_next;
        col_in_reg  <= col_in_next;
        row_in_reg  <= row_in_next;
        cnt_reg     <= cnt_next;
        scroll_reg  <= scroll_next;
        wr_addr_reg <= wr_addr_next;
        wr_mem_reg  <= wr_mem_next;
        wr_data_reg <= wr_data_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Writes are registered and land in the cycle after their read, so a scroll
    // copies the row below from the registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en_reg) begin
            mem[wr_addr_reg] <= wr_mem_reg ? rd_data_reg : wr_data_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_unit.
module tcw_checker
    import tcw_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken before the first completed");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] < COL_W'(COLUMNS)) && (m_tdata[27:23] < ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_cursor_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:28] ==
            IDX_W'(int'(m_tdata[27:23]) * COLUMNS + int'(m_tdata[22:16])))
        else $error("cursor index does not match cursor position");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[39])
        else $error("pad bit set");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
